@@ src/efr_pkg.sv @@
// Shared types and constants for the escaped frame receiver.
package efr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned OutCntW = 10;
  localparam int unsigned MaxLenW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [KindW-1:0] EV_START    = 3'd0;
  localparam logic [KindW-1:0] EV_BODY     = 3'd1;
  localparam logic [KindW-1:0] EV_END      = 3'd2;
  localparam logic [KindW-1:0] EV_ESC_ERR  = 3'd3;
  localparam logic [KindW-1:0] EV_OVERFLOW = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_FLAG_BYTE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ESCAPE_BYTE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ESC_FLAG     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ESC_ESCAPE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_LEN      = 3'd4;

  localparam logic [ByteW-1:0]   FLAG_RESET       = 8'd126;
  localparam logic [ByteW-1:0]   ESCAPE_RESET     = 8'd125;
  localparam logic [ByteW-1:0]   ESC_FLAG_RESET   = 8'd2;
  localparam logic [ByteW-1:0]   ESC_ESCAPE_RESET = 8'd1;
  localparam logic [MaxLenW-1:0] MAX_LEN_RESET    = 10'd512;

  typedef struct packed {
    logic [ByteW-1:0]   flag_byte;
    logic [ByteW-1:0]   escape_byte;
    logic [ByteW-1:0]   escaped_flag_code;
    logic [ByteW-1:0]   escaped_escape_code;
    logic [MaxLenW-1:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic in_frame;
    logic escape_pending;
  } flags_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
  } result_t;

endpackage

@@ src/escaped_frame_receiver_unit.sv @@
// Top level of the escaped frame receiver: configuration, input stage and result register.
//
// Raw link bytes arrive on the input channel (in_valid, in_stall, rx_byte); each
// accepted request is one byte. Deframing events leave on the output channel
// (out_valid, out_stall, frame_byte, event_kind, byte_count): a frame start, an
// unescaped body byte, a frame end, an escape error or an overflow abort. A byte
// outside a frame that is not the flag, and a held escape byte, give no event.
// An accepted byte is held in the input register; its event, if any, is
// registered in the result register as the byte leaves the input register. One byte
// is taken per cycle, limited only by the output side: while a result waits under
// out_stall, one more byte is held in the input register and in_stall then rises.
// Frame state advances as a byte leaves the input register.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// and should only change while no byte is in flight. Synchronous reset empties
// both stages, leaves the block outside any frame and restores default register
// values (flag 126, escape 125, codes 2 and 1, maximum length 512).
module escaped_frame_receiver_unit #(
  parameter int unsigned FRAME_LIMIT = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [efr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [efr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [efr_pkg::ByteW-1:0]    rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [efr_pkg::ByteW-1:0]    frame_byte,
  output logic [efr_pkg::KindW-1:0]    event_kind,
  output logic [efr_pkg::OutCntW-1:0]  byte_count
);

  localparam int unsigned CW = $clog2(FRAME_LIMIT + 1);
  localparam int unsigned LW = (CW > efr_pkg::OutCntW) ? CW : efr_pkg::OutCntW;

  efr_pkg::cfg_t             cfg;
  efr_pkg::flags_t           flags;
  efr_pkg::flags_t           flags_next;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  efr_pkg::result_t          res;
  logic                      stage_valid;
  logic [efr_pkg::ByteW-1:0] stage_byte;
  logic                      stage_adv;
  logic                      in_take;
  logic [LW-1:0]             count_ext;

  assign stage_adv = !out_valid || !out_stall;
  assign in_stall  = stage_valid && !stage_adv;
  assign in_take   = in_valid && !in_stall;
  assign count_ext = LW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte           <= efr_pkg::FLAG_RESET;
      cfg.escape_byte         <= efr_pkg::ESCAPE_RESET;
      cfg.escaped_flag_code   <= efr_pkg::ESC_FLAG_RESET;
      cfg.escaped_escape_code <= efr_pkg::ESC_ESCAPE_RESET;
      cfg.max_frame_length    <= efr_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        efr_pkg::REG_FLAG_BYTE:   cfg.flag_byte <= cfg_data[efr_pkg::ByteW-1:0];
        efr_pkg::REG_ESCAPE_BYTE: cfg.escape_byte <= cfg_data[efr_pkg::ByteW-1:0];
        efr_pkg::REG_ESC_FLAG:    cfg.escaped_flag_code <= cfg_data[efr_pkg::ByteW-1:0];
        efr_pkg::REG_ESC_ESCAPE:  cfg.escaped_escape_code <= cfg_data[efr_pkg::ByteW-1:0];
        efr_pkg::REG_MAX_LEN:     cfg.max_frame_length <= cfg_data[efr_pkg::MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (stage_adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte <= rx_byte;
    end
  end

  efr_decode #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_decode (
    .cfg       (cfg),
    .flags     (flags),
    .count     (count),
    .rx        (stage_byte),
    .flags_next(flags_next),
    .count_next(count_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else if (stage_valid && stage_adv) begin
      flags     <= flags_next;
      count     <= count_next;
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_adv && res.valid) begin
      frame_byte <= res.data;
      event_kind <= res.kind;
      byte_count <= count_ext[efr_pkg::OutCntW-1:0];
    end
  end

endmodule

@@ src/efr_decode.sv @@
// Per-byte deframing step: next state and optional result for one received byte.
module efr_decode #(
  parameter int unsigned FRAME_LIMIT = 512
) (
  input  efr_pkg::cfg_t                      cfg,
  input  efr_pkg::flags_t                    flags,
  input  logic [$clog2(FRAME_LIMIT+1)-1:0]   count,
  input  logic [efr_pkg::ByteW-1:0]          rx,
  output efr_pkg::flags_t                    flags_next,
  output logic [$clog2(FRAME_LIMIT+1)-1:0]   count_next,
  output efr_pkg::result_t                   res
);

  localparam int unsigned CW = $clog2(FRAME_LIMIT + 1);
  localparam int unsigned LW = (CW > efr_pkg::MaxLenW) ? CW : efr_pkg::MaxLenW;
  localparam logic [LW-1:0] LimitMax = LW'(FRAME_LIMIT);

  logic [CW-1:0]             count_inc;
  logic [LW-1:0]             max_len_ext;
  logic [LW-1:0]             limit;
  logic                      over;
  logic [efr_pkg::ByteW-1:0] body_val;
  logic                      body_go;

  assign count_inc   = count + CW'(1);
  assign max_len_ext = LW'(cfg.max_frame_length);
  assign limit       = (max_len_ext > LimitMax) ? LimitMax : max_len_ext;
  assign over        = LW'(count_inc) >= limit;

  always_comb begin
    flags_next = flags;
    count_next = count;
    res        = '0;
    body_go    = 1'b0;
    body_val   = rx;
    if (!flags.in_frame) begin
      if (rx == cfg.flag_byte) begin
        flags_next.in_frame       = 1'b1;
        flags_next.escape_pending = 1'b0;
        count_next = CW'(1);
        res.valid  = 1'b1;
        res.kind   = efr_pkg::EV_START;
        res.data   = cfg.flag_byte;
      end
    end else if (flags.escape_pending) begin
      flags_next.escape_pending = 1'b0;
      if (rx == cfg.escaped_flag_code) begin
        body_go  = 1'b1;
        body_val = cfg.flag_byte;
      end else if (rx == cfg.escaped_escape_code) begin
        body_go  = 1'b1;
        body_val = cfg.escape_byte;
      end else begin
        count_next          = count_inc;
        flags_next.in_frame = 1'b0;
        res.valid = 1'b1;
        res.kind  = efr_pkg::EV_ESC_ERR;
        res.data  = rx;
      end
    end else if (rx == cfg.escape_byte) begin
      flags_next.escape_pending = 1'b1;
    end else if (rx == cfg.flag_byte) begin
      res.valid = 1'b1;
      res.data  = cfg.flag_byte;
      if (count == CW'(1)) begin
        count_next = CW'(1);
        res.kind   = efr_pkg::EV_START;
      end else begin
        count_next          = count_inc;
        flags_next.in_frame = 1'b0;
        res.kind            = efr_pkg::EV_END;
      end
    end else begin
      body_go = 1'b1;
    end

    if (body_go) begin
      count_next = count_inc;
      res.valid  = 1'b1;
      res.data   = body_val;
      if (over) begin
        flags_next.in_frame = 1'b0;
        res.kind            = efr_pkg::EV_OVERFLOW;
      end else begin
        res.kind = efr_pkg::EV_BODY;
      end
    end
  end

endmodule

@@ src/efr_checker.sv @@
// Port-level checks for the escaped frame receiver, bound to the top level.
module efr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [efr_pkg::ByteW-1:0]   frame_byte,
  input logic [efr_pkg::KindW-1:0]   event_kind,
  input logic [efr_pkg::OutCntW-1:0] byte_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_byte) &&
      $stable(event_kind) && $stable(byte_count))
    else $error("Stalled result changed or was dropped.");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind == efr_pkg::EV_START || event_kind == efr_pkg::EV_BODY ||
      event_kind == efr_pkg::EV_END || event_kind == efr_pkg::EV_ESC_ERR ||
      event_kind == efr_pkg::EV_OVERFLOW)
    else $error("Result carries an undefined event kind.");

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == efr_pkg::EV_START |-> byte_count == 10'd1)
    else $error("Frame start does not report a count of one.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .frame_byte(frame_byte),
  .event_kind(event_kind),
  .byte_count(byte_count)
);

@@ tb/sv/escaped_frame_receiver_checker.sv @@
// Checker for the escaped frame receiver: predicts deframing events from accepted bytes and compares them.
module escaped_frame_receiver_checker #(
  parameter int unsigned FRAME_LIMIT = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [efr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [efr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [efr_pkg::ByteW-1:0]    rx_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [efr_pkg::ByteW-1:0]    frame_byte,
  input  logic [efr_pkg::KindW-1:0]    event_kind,
  input  logic [efr_pkg::OutCntW-1:0]  byte_count,
  output int                           fail_count,
  output int                           pending,
  output int                           bytes_taken,
  output int                           events_checked,
  output int                           aborts_seen
);
  import efr_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [KindW-1:0]   kind;
    logic [OutCntW-1:0] count;
  } frame_event_t;

  frame_event_t       expected_events[$];
  cfg_t               cfg;
  logic               in_frame_q;
  logic               esc_held_q;
  logic [OutCntW-1:0] frame_cnt_q;
  int                 fails = 0;
  int                 taken = 0;
  int                 checked = 0;
  int                 aborts = 0;

  // Advances the frame state by one raw byte; returns 1 when the byte causes an event.
  function automatic logic deframe_byte(input logic [ByteW-1:0] b, output frame_event_t ev);
    int               lim;
    logic [ByteW-1:0] body;
    lim = (cfg.max_frame_length > FRAME_LIMIT) ? FRAME_LIMIT : int'(cfg.max_frame_length);
    ev = '0;
    if (!in_frame_q) begin
      if (b != cfg.flag_byte) return 1'b0;
      in_frame_q = 1'b1;
      esc_held_q = 1'b0;
      frame_cnt_q = OutCntW'(1);
      ev = {cfg.flag_byte, EV_START, frame_cnt_q};
      return 1'b1;
    end
    if (esc_held_q) begin
      esc_held_q = 1'b0;
      if (b == cfg.escaped_flag_code) begin
        body = cfg.flag_byte;
      end else if (b == cfg.escaped_escape_code) begin
        body = cfg.escape_byte;
      end else begin
        frame_cnt_q = frame_cnt_q + 1'b1;
        in_frame_q = 1'b0;
        ev = {b, EV_ESC_ERR, frame_cnt_q};
        return 1'b1;
      end
    end else if (b == cfg.escape_byte) begin
      esc_held_q = 1'b1;
      return 1'b0;
    end else if (b == cfg.flag_byte) begin
      // A flag right after the opening flag starts the frame over.
      if (frame_cnt_q == 1) begin
        ev = {cfg.flag_byte, EV_START, frame_cnt_q};
        return 1'b1;
      end
      frame_cnt_q = frame_cnt_q + 1'b1;
      in_frame_q = 1'b0;
      ev = {cfg.flag_byte, EV_END, frame_cnt_q};
      return 1'b1;
    end else begin
      body = b;
    end
    frame_cnt_q = frame_cnt_q + 1'b1;
    if (int'(frame_cnt_q) >= lim) begin
      in_frame_q = 1'b0;
      ev = {body, EV_OVERFLOW, frame_cnt_q};
    end else begin
      ev = {body, EV_BODY, frame_cnt_q};
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    frame_event_t got;
    frame_event_t want;
    frame_event_t next_ev;
    if (rst) begin
      cfg = {FLAG_RESET, ESCAPE_RESET, ESC_FLAG_RESET, ESC_ESCAPE_RESET, MAX_LEN_RESET};
      in_frame_q = 1'b0;
      esc_held_q = 1'b0;
      frame_cnt_q = '0;
      expected_events.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FLAG_BYTE: begin
            cfg.flag_byte = cfg_data[ByteW-1:0];
          end
          REG_ESCAPE_BYTE: begin
            cfg.escape_byte = cfg_data[ByteW-1:0];
          end
          REG_ESC_FLAG: begin
            cfg.escaped_flag_code = cfg_data[ByteW-1:0];
          end
          REG_ESC_ESCAPE: begin
            cfg.escaped_escape_code = cfg_data[ByteW-1:0];
          end
          REG_MAX_LEN: begin
            cfg.max_frame_length = cfg_data[MaxLenW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {frame_byte, event_kind, byte_count};
        if (expected_events.size() == 0) begin
          $error("unexpected event: frame_byte %0d event_kind %0d byte_count %0d",
                 frame_byte, event_kind, byte_count);
          fails++;
        end else begin
          want = expected_events.pop_front();
          checked++;
          if (want.kind == EV_ESC_ERR || want.kind == EV_OVERFLOW) aborts++;
          if (got.data !== want.data) begin
            $error("frame_byte: expected %0d, actual %0d", want.data, got.data);
            fails++;
          end
          if (got.kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
            fails++;
          end
          if (got.count !== want.count) begin
            $error("byte_count: expected %0d, actual %0d", want.count, got.count);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        taken++;
        if (deframe_byte(rx_byte, next_ev)) expected_events.push_back(next_ev);
      end
    end
    pending <= expected_events.size();
    fail_count <= fails;
    bytes_taken <= taken;
    events_checked <= checked;
    aborts_seen <= aborts;
  end

endmodule

@@ tb/sv/escaped_frame_receiver_unit_tb.sv @@
// Testbench top for the escaped frame receiver: clock, reset, byte and configuration stimulus, verdict.
module escaped_frame_receiver_unit_tb;
  import efr_pkg::*;

  localparam int unsigned FRAME_LIMIT  = 512;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [ByteW-1:0]    rx_byte;
  logic                out_valid;
  logic                out_stall;
  logic [ByteW-1:0]    frame_byte;
  logic [KindW-1:0]    event_kind;
  logic [OutCntW-1:0]  byte_count;

  int fail_count;
  int pending;
  int bytes_taken;
  int events_checked;
  int aborts_seen;

  logic [ByteW-1:0] flag_v;
  logic [ByteW-1:0] esc_v;
  logic [ByteW-1:0] code_f_v;
  logic [ByteW-1:0] code_e_v;
  int               max_len_v;
  int               bytes_sent = 0;
  int               configs_used = 1;
  int               cycle_cnt = 0;
  logic             calm = 1'b0;
  logic             long_hold_req = 1'b0;

  escaped_frame_receiver_unit #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .event_kind(event_kind),
    .byte_count(byte_count)
  );

  escaped_frame_receiver_checker #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) event_check (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .event_kind(event_kind),
    .byte_count(byte_count),
    .fail_count(fail_count),
    .pending(pending),
    .bytes_taken(bytes_taken),
    .events_checked(events_checked),
    .aborts_seen(aborts_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("escaped_frame_receiver_unit_tb failed");
      $finish;
    end
  end

  // The result side stalls in runs; a long hold-off lets the block fill up and stall its input.
  initial begin
    int   run_left;
    logic run_val;
    out_stall = 1'b0;
    run_left = 0;
    run_val = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        run_val = 1'b1;
        run_left = 200;
      end else if (run_left == 0) begin
        run_val = calm ? 1'b0 : ($urandom_range(0, 2) == 0);
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      end
      out_stall <= run_val;
      run_left--;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) >= 55)
      gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [ByteW-1:0] f, input logic [ByteW-1:0] e,
                           input logic [ByteW-1:0] cf, input logic [ByteW-1:0] ce,
                           input int ml);
    drain();
    write_reg(REG_FLAG_BYTE, CfgDataW'(f));
    write_reg(REG_ESCAPE_BYTE, CfgDataW'(e));
    write_reg(REG_ESC_FLAG, CfgDataW'(cf));
    write_reg(REG_ESC_ESCAPE, CfgDataW'(ce));
    write_reg(REG_MAX_LEN, CfgDataW'(ml));
    flag_v = f;
    esc_v = e;
    code_f_v = cf;
    code_e_v = ce;
    max_len_v = ml;
    configs_used++;
  endtask

  // One frame: opening flag, a body of mostly plain and escaped bytes with some faults, usually a closing flag.
  task automatic send_frame(input int body_len);
    int               i;
    int               r;
    logic [ByteW-1:0] b;
    if ($urandom_range(0, 19) == 0) send_byte(flag_v);
    send_byte(flag_v);
    for (i = 0; i < body_len; i++) begin
      r = $urandom_range(0, 99);
      b = ByteW'($urandom_range(0, 255));
      if (r < 78) begin
        if (b == flag_v || b == esc_v) begin
          send_byte(esc_v);
          send_byte((b == flag_v) ? code_f_v : code_e_v);
        end else begin
          send_byte(b);
        end
      end else if (r < 92) begin
        send_byte(esc_v);
        send_byte($urandom_range(0, 1) ? code_f_v : code_e_v);
      end else if (r < 95) begin
        send_byte(esc_v);
        while (b == code_f_v || b == code_e_v) b = ByteW'($urandom_range(0, 255));
        send_byte(b);
      end else if (r < 97) begin
        send_byte(flag_v);
      end else begin
        send_byte(b);
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(flag_v);
  endtask

  task automatic run_traffic(input int n);
    int first;
    int noise;
    int lim;
    int short_max;
    int len;
    int k;
    first = bytes_sent;
    noise = 0;
    lim = (max_len_v > FRAME_LIMIT) ? FRAME_LIMIT : max_len_v;
    short_max = (lim + 1 < 16) ? lim + 1 : 16;
    send_frame(lim);
    while (bytes_sent - first - noise < n) begin
      if ($urandom_range(0, 9) == 0) begin
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          send_byte(ByteW'($urandom_range(0, 255)));
          noise++;
        end
      end
      len = ($urandom_range(0, 99) < 3) ? $urandom_range(0, lim + 2)
                                        : $urandom_range(0, short_max);
      send_frame(len);
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    flag_v = FLAG_RESET;
    esc_v = ESCAPE_RESET;
    code_f_v = ESC_FLAG_RESET;
    code_e_v = ESC_ESCAPE_RESET;
    max_len_v = MAX_LEN_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default registers: idle bytes, restart, extreme body bytes, both escape pairs and
    // escape errors, including a flag and a second escape after the escape byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(flag_v);
    send_byte(flag_v);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(esc_v);
    send_byte(code_f_v);
    send_byte(esc_v);
    send_byte(code_e_v);
    send_byte(flag_v);
    send_byte(flag_v);
    send_byte(8'h41);
    send_byte(esc_v);
    send_byte(8'h33);
    send_byte(esc_v);
    send_byte(flag_v);
    send_byte(esc_v);
    send_byte(flag_v);
    send_byte(flag_v);
    send_byte(esc_v);
    send_byte(esc_v);
    long_hold_req = 1'b1;
    run_traffic(600);

    // Shortest frame limit: a closing flag at the limit ends the frame, a body byte aborts it.
    configure(FLAG_RESET, ESCAPE_RESET, ESC_FLAG_RESET, ESC_ESCAPE_RESET, 3);
    send_byte(flag_v);
    send_byte(flag_v);
    send_byte(8'h11);
    send_byte(flag_v);
    send_byte(flag_v);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(flag_v);
    send_byte(8'h11);
    send_byte(esc_v);
    send_byte(code_f_v);
    run_traffic(200);

    configure(8'h00, 8'hFF, 8'hFF, 8'h00, 512);
    run_traffic(300);

    // Escape equal to flag and both codes equal.
    configure(8'h55, 8'h55, 8'h10, 8'h10, 20);
    send_byte(flag_v);
    send_byte(flag_v);
    send_byte(8'h10);
    run_traffic(250);

    calm = 1'b1;
    configure(8'hFF, 8'h00, 8'h80, 8'h7F, 100);
    run_traffic(200);
    calm = 1'b0;

    for (i = 0; i < 3; i++) begin
      configure(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                $urandom_range(3, 40));
      run_traffic(100);
    end

    drain();

    $display("Run covered %0d link bytes under %0d register settings.", bytes_taken,
             configs_used);
    $display("It checked %0d events, %0d of them escape errors or overflows.", events_checked,
             aborts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("escaped_frame_receiver_unit_tb passed");
    end else begin
      $display("escaped_frame_receiver_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/efr_pkg.sv
src/efr_decode.sv
src/escaped_frame_receiver_unit.sv
src/efr_checker.sv
tb/sv/escaped_frame_receiver_checker.sv
tb/sv/escaped_frame_receiver_unit_tb.sv
